// ===== src/lgs_pkg.sv =====
package lgs_pkg;

   // default grid size
   localparam int ROWS_DEF = 12;
   localparam int COLS_DEF = 20;

   // fixed field widths
   localparam int PIXEL_X_W   = 10;
   localparam int PIXEL_Y_W   = 9;
   localparam int ROW_INDEX_W = 4;

   // reciprocals of the cell pitch (50 rows, 33 columns) scaled by 2^16
   localparam int ROW_PITCH_RECIP = 1311;
   localparam int COL_PITCH_RECIP = 1986;
   localparam int RECIP_SHIFT     = 16;
   localparam int PROD_Y_W        = 20;
   localparam int PROD_X_W        = 21;

   // request kinds
   typedef enum logic {
      ACT_TOGGLE = 1'b0,
      ACT_STEP   = 1'b1
   } action_type;

endpackage

// ===== src/lgs_grid_mem.sv =====
module lgs_grid_mem #(
   parameter int ROWS = lgs_pkg::ROWS_DEF,
   parameter int COLS = lgs_pkg::COLS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [$clog2(ROWS)-1:0] rd_addr,
   output logic [COLS-1:0]         rd_data,
   input  logic                    wr_en,
   input  logic [$clog2(ROWS)-1:0] wr_addr,
   input  logic [COLS-1:0]         wr_data
);
   import lgs_pkg::*;

   logic [COLS-1:0] grid_ff [ROWS];
   logic [ROWS-1:0] row_vld_ff;
   logic [ROWS-1:0] row_vld_in;
   logic [COLS-1:0] data_ff;
   logic            data_vld_ff;
   logic            data_vld_in;

   // mark rows as written; an unwritten row reads as all dead
   always_comb begin
      row_vld_in = row_vld_ff;
      if (wr_en) begin
         row_vld_in[wr_addr] = 1'b1;
      end
   end

   assign data_vld_in = rd_en ? row_vld_ff[rd_addr] : data_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff  <= '0;
         data_vld_ff <= 1'b0;
      end else begin
         row_vld_ff  <= row_vld_in;
         data_vld_ff <= data_vld_in;
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds its word when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= grid_ff[rd_addr];
      end
   end

   assign rd_data = data_vld_ff ? data_ff : '0;

endmodule

// ===== src/lgs_row_unit.sv =====
module lgs_row_unit #(
   parameter int COLS = lgs_pkg::COLS_DEF
) (
   input  logic [COLS-1:0] row_up,
   input  logic [COLS-1:0] row_mid,
   input  logic [COLS-1:0] row_dn,
   output logic [COLS-1:0] row_next
);
   import lgs_pkg::*;

   // apply B3/S23 to each interior column; border columns hold
   always_comb begin
      logic [3:0] nbr;
      row_next = row_mid;
      for (int c = 1; c < COLS - 1; c++) begin
         nbr = 4'(row_up[c-1]) + 4'(row_up[c]) + 4'(row_up[c+1])
             + 4'(row_mid[c-1]) + 4'(row_mid[c+1])
             + 4'(row_dn[c-1]) + 4'(row_dn[c]) + 4'(row_dn[c+1]);
         row_next[c] = (nbr == 4'd3) || (row_mid[c] && (nbr == 4'd2));
      end
   end

endmodule

// ===== src/lgs_pixel_map.sv =====
module lgs_pixel_map #(
   parameter int ROWS = lgs_pkg::ROWS_DEF,
   parameter int COLS = lgs_pkg::COLS_DEF
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic [lgs_pkg::PIXEL_X_W-1:0]  pixel_x,
   input  logic [lgs_pkg::PIXEL_Y_W-1:0]  pixel_y,
   output logic [$clog2(ROWS)-1:0]        tog_row,
   output logic [$clog2(COLS)-1:0]        tog_col
);
   import lgs_pkg::*;

   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLS);
   localparam int QY_W  = PROD_Y_W - RECIP_SHIFT;
   localparam int QX_W  = PROD_X_W - RECIP_SHIFT;

   logic [PIXEL_Y_W-1:0] y_m1;
   logic [PIXEL_X_W-1:0] x_m1;
   logic [PROD_Y_W-1:0]  prod_y;
   logic [PROD_X_W-1:0]  prod_x;
   logic [QY_W-1:0]      qy_ff;
   logic [QX_W-1:0]      qx_ff;
   logic                 y_zero_ff;
   logic                 x_zero_ff;
   logic [7:0]           row_raw;
   logic [7:0]           row_clip;
   logic [7:0]           col_top;
   logic [7:0]           col_cnt;

   // divide (pixel - 1) by the pitch through a scaled reciprocal
   assign y_m1   = pixel_y - 1'b1;
   assign x_m1   = pixel_x - 1'b1;
   assign prod_y = PROD_Y_W'(y_m1) * PROD_Y_W'(ROW_PITCH_RECIP);
   assign prod_x = PROD_X_W'(x_m1) * PROD_X_W'(COL_PITCH_RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         qy_ff     <= prod_y[PROD_Y_W-1:RECIP_SHIFT];
         qx_ff     <= prod_x[PROD_X_W-1:RECIP_SHIFT];
         y_zero_ff <= (pixel_y == '0);
         x_zero_ff <= (pixel_x == '0);
      end
   end

   // row: one past the quotient, capped at the last interior row
   assign row_raw  = 8'(qy_ff) + 8'd1;
   assign row_clip = (row_raw > 8'(ROWS - 2)) ? 8'(ROWS - 2) : row_raw;
   assign tog_row  = y_zero_ff ? '0 : row_clip[ROW_W-1:0];

   // column: count of pitches from two up to the cap
   assign col_top = (8'(qx_ff) > 8'(COLS - 2)) ? 8'(COLS - 2) : 8'(qx_ff);
   assign col_cnt = (col_top >= 8'd2) ? (col_top - 8'd1) : 8'd0;
   assign tog_col = x_zero_ff ? '0 : col_cnt[COL_W-1:0];

endmodule

// ===== src/life_grid_stepper_core.sv =====
// A request is accepted only while idle; then comes the mapping state, then
// ROWS+1 pass steps through the three-row window, each held while the result
// register keeps an untaken word. Result words follow from the fourth step,
// one per cycle while results are taken; no new request is taken until the
// pass ends. Reset (synchronous, active high) idles the sequencer,
// empties the result register and clears the row valid bits, so the grid reads dead.
module life_grid_stepper_core #(
   parameter int ROWS = lgs_pkg::ROWS_DEF,
   parameter int COLS = lgs_pkg::COLS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [lgs_pkg::PIXEL_X_W-1:0]   req_pixel_x,
   input  logic [lgs_pkg::PIXEL_Y_W-1:0]   req_pixel_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lgs_pkg::ROW_INDEX_W-1:0] rsp_row_index,
   output logic [COLS-3:0]                 rsp_row_bits,
   output logic                            rsp_last_row
);
   import lgs_pkg::*;

   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLS);
   localparam int K_W   = $clog2(ROWS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MAP  = 3'b010,
      ST_PASS = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [K_W-1:0]          k_ff, k_in;
   logic                    step_ff;
   logic [PIXEL_X_W-1:0]    x_ff;
   logic [PIXEL_Y_W-1:0]    y_ff;
   logic [COLS-1:0]         up_ff;
   logic [COLS-1:0]         mid_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_INDEX_W-1:0]  rsp_row_index_ff;
   logic [COLS-3:0]         rsp_row_bits_ff;
   logic                    rsp_last_row_ff;

   logic                    accept;
   logic                    advance;
   logic                    rd_en;
   logic [COLS-1:0]         rd_data;
   logic                    wr_en;
   logic [K_W-1:0]          wr_row;
   logic [COLS-1:0]         wr_data;
   logic [COLS-1:0]         life_row;
   logic [COLS-1:0]         tog_mask;
   logic [ROW_W-1:0]        tog_row;
   logic [COL_W-1:0]        tog_col;
   logic                    emit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // the pass moves only when the result register can take a word
   assign advance = (state_ff == ST_PASS) && (!rsp_valid_ff || rsp_ready);
   assign rd_en   = advance && (k_ff < K_W'(ROWS));
   assign wr_row  = k_ff - K_W'(2);
   assign wr_en   = advance && (k_ff >= K_W'(2));
   assign emit    = advance && (k_ff >= K_W'(3));

   lgs_grid_mem #(.ROWS(ROWS), .COLS(COLS)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (k_ff[ROW_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_row[ROW_W-1:0]),
      .wr_data (wr_data)
   );

   lgs_row_unit #(.COLS(COLS)) u_row (
      .row_up   (up_ff),
      .row_mid  (mid_ff),
      .row_dn   (rd_data),
      .row_next (life_row)
   );

   lgs_pixel_map #(.ROWS(ROWS), .COLS(COLS)) u_map (
      .clock   (clock),
      .load    (state_ff == ST_MAP),
      .pixel_x (x_ff),
      .pixel_y (y_ff),
      .tog_row (tog_row),
      .tog_col (tog_col)
   );

   // pick the row to write back: next generation or toggled old row
   always_comb begin
      tog_mask = '0;
      if (!step_ff && (tog_row == wr_row[ROW_W-1:0])) begin
         tog_mask = COLS'(1) << tog_col;
      end
      if (step_ff && (k_ff >= K_W'(3))) begin
         wr_data = life_row;
      end else begin
         wr_data = mid_ff ^ tog_mask;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MAP;
               k_in     = '0;
            end
         end
         ST_MAP: begin
            state_in = ST_PASS;
         end
         ST_PASS: begin
            if (advance) begin
               k_in = k_ff + K_W'(1);
               if (k_ff == K_W'(ROWS)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff <= (req_action == ACT_STEP);
         x_ff    <= req_pixel_x;
         y_ff    <= req_pixel_y;
      end
   end

   // advance the three-row window
   always_ff @(posedge clock) begin
      if (advance) begin
         up_ff  <= mid_ff;
         mid_ff <= rd_data;
      end
   end

   // result register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_index_ff <= ROW_INDEX_W'(wr_row);
         rsp_row_bits_ff  <= wr_data[COLS-2:1];
         rsp_last_row_ff  <= (wr_row == K_W'(ROWS - 2));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_index_ff;
   assign rsp_row_bits  = rsp_row_bits_ff;
   assign rsp_last_row  = rsp_last_row_ff;

endmodule
